// ===== hw/rtl/fkdeb_pkg.sv =====
// Shared types and constants for the four-key debouncer.
package fkdeb_pkg;

  localparam int MaskWidth = 4;
  localparam int WordWidth = 16;
  localparam int CodeWidth = 3;

  localparam logic [CodeWidth-1:0] CODE_NONE = 3'd0;
  localparam logic [CodeWidth-1:0] CODE_LONG = 3'd5;

  typedef enum logic [1:0] {
    CFG_REPEAT_ENABLE   = 2'd0,
    CFG_REPEAT_PERIOD   = 2'd1,
    CFG_LONG_HOLD_TICKS = 2'd2,
    CFG_LONG_COUNT      = 2'd3
  } cfg_index_t;

  localparam logic                 RESET_REPEAT_ENABLE   = 1'b0;
  localparam logic [WordWidth-1:0] RESET_REPEAT_PERIOD   = 16'd5;
  localparam logic [WordWidth-1:0] RESET_LONG_HOLD_TICKS = 16'd60000;
  localparam logic [WordWidth-1:0] RESET_LONG_COUNT      = 16'd600;

  typedef struct packed {
    logic                 repeat_enable;
    logic [WordWidth-1:0] repeat_period;
    logic [WordWidth-1:0] long_hold_ticks;
    logic [WordWidth-1:0] long_count;
  } cfg_t;

  // What one key lane reports for the current tick.
  typedef struct packed {
    logic fire;
    logic is_long;
  } lane_evt_t;

endpackage

// ===== hw/rtl/fkdeb_if.sv =====
// Handshake interfaces for the key scan items and the event items.
interface fkdeb_key_if;
  logic                             valid;
  logic                             ready;
  logic [fkdeb_pkg::MaskWidth-1:0] pressed_mask;

  modport source (output valid, output pressed_mask, input ready);
  modport sink (input valid, input pressed_mask, output ready);
endinterface

interface fkdeb_event_if;
  logic                             valid;
  logic                             ready;
  logic [fkdeb_pkg::CodeWidth-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

// ===== hw/rtl/fkdeb_lane.sv =====
// One key lane: debounce state machine, hold counter and optional long-press wait.
module fkdeb_lane #(
  parameter bit HAS_LONG = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 down,
  input  fkdeb_pkg::cfg_t      cfg,
  output fkdeb_pkg::lane_evt_t evt
);

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_DEBOUNCE     = 2'd1,
    PH_PRESSED      = 2'd2,
    PH_WAIT_RELEASE = 2'd3
  } phase_t;

  phase_t                              phase;
  phase_t                              phase_next;
  logic [fkdeb_pkg::WordWidth-1:0]     hold;
  logic [fkdeb_pkg::WordWidth-1:0]     hold_next;
  logic [fkdeb_pkg::WordWidth-1:0]     long_wait;
  logic [fkdeb_pkg::WordWidth-1:0]     long_wait_next;
  logic [fkdeb_pkg::WordWidth-1:0]     hold_inc;
  logic [fkdeb_pkg::WordWidth-1:0]     wait_inc;

  assign hold_inc = hold + 16'd1;
  assign wait_inc = long_wait + 16'd1;

  always_comb begin
    phase_next     = phase;
    hold_next      = hold;
    long_wait_next = long_wait;
    evt            = '0;
    unique case (phase)
      PH_IDLE: begin
        if (down) begin
          phase_next = PH_DEBOUNCE;
          hold_next  = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (down) begin
          phase_next = PH_PRESSED;
          hold_next  = '0;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          phase_next = PH_IDLE;
          evt.fire   = 1'b1;
        end else begin
          hold_next = hold_inc;
          if (HAS_LONG && hold_inc >= cfg.long_hold_ticks) begin
            long_wait_next = wait_inc;
            if (wait_inc >= cfg.long_count) begin
              evt.fire       = 1'b1;
              evt.is_long    = 1'b1;
              long_wait_next = '0;
              phase_next     = PH_WAIT_RELEASE;
            end
          end else if (cfg.repeat_enable && hold_inc >= cfg.repeat_period) begin
            evt.fire  = 1'b1;
            hold_next = '0;
          end
        end
      end
      PH_WAIT_RELEASE: begin
        if (!down) begin
          phase_next     = PH_IDLE;
          hold_next      = '0;
          long_wait_next = '0;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      hold      <= '0;
      long_wait <= '0;
    end else if (step) begin
      phase     <= phase_next;
      hold      <= hold_next;
      long_wait <= long_wait_next;
    end
  end

endmodule

// ===== hw/rtl/fkdeb_merge.sv =====
// Priority merge of the lane reports into one event code, highest key first.
module fkdeb_merge #(
  parameter int KEY_COUNT = 4
) (
  input  fkdeb_pkg::lane_evt_t             evt [KEY_COUNT],
  output logic [fkdeb_pkg::CodeWidth-1:0] code
);

  always_comb begin
    code = fkdeb_pkg::CODE_NONE;
    // Later lanes override earlier ones, so the highest-numbered key wins.
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (evt[i].fire) begin
        code = evt[i].is_long ? fkdeb_pkg::CODE_LONG : fkdeb_pkg::CodeWidth'(i + 1);
      end
    end
  end

endmodule

// ===== hw/rtl/four_key_debouncer_repeat_long_press_top.sv =====
// Key debouncer with auto-repeat and long press: lanes, merge and output register.
// Latency: the event item for a scan item is valid in the cycle after the scan is accepted.
// Throughput: one scan item per cycle; the single output register lets a new scan in
// whenever it is empty or its event is taken in the same cycle.
// Reset (rst, synchronous, active high): all keys idle, hold and long-wait counters zero,
// output empty, registers back to repeat off, period 5, hold 60000, long count 600.
module four_key_debouncer_repeat_long_press_top #(
  parameter int KEY_COUNT      = 4,
  parameter int LONG_KEY_INDEX = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  fkdeb_key_if.sink                       keys,
  fkdeb_event_if.source                   events,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [fkdeb_pkg::WordWidth-1:0] cfg_data
);

  // Configuration registers. Writes are to arrive only while the block is idle; the block does not enforce this.
  fkdeb_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_enable   <= fkdeb_pkg::RESET_REPEAT_ENABLE;
      cfg.repeat_period   <= fkdeb_pkg::RESET_REPEAT_PERIOD;
      cfg.long_hold_ticks <= fkdeb_pkg::RESET_LONG_HOLD_TICKS;
      cfg.long_count      <= fkdeb_pkg::RESET_LONG_COUNT;
    end else if (cfg_we) begin
      unique case (fkdeb_pkg::cfg_index_t'(cfg_index))
        fkdeb_pkg::CFG_REPEAT_ENABLE:   cfg.repeat_enable   <= cfg_data[0];
        fkdeb_pkg::CFG_REPEAT_PERIOD:   cfg.repeat_period   <= cfg_data;
        fkdeb_pkg::CFG_LONG_HOLD_TICKS: cfg.long_hold_ticks <= cfg_data;
        fkdeb_pkg::CFG_LONG_COUNT:      cfg.long_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // The scan is taken when the output register is free or drains this cycle.
  logic out_valid;
  logic step;

  assign keys.ready = !out_valid || events.ready;
  assign step       = keys.valid && keys.ready;

  // One lane per key. Keys beyond the width of the scan mask never see a press,
  // and only the lane at LONG_KEY_INDEX carries the long-press wait counter.
  logic [KEY_COUNT-1:0]  down;
  fkdeb_pkg::lane_evt_t  lane_evt [KEY_COUNT];

  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
    if (i < fkdeb_pkg::MaskWidth) begin : g_in
      assign down[i] = keys.pressed_mask[i];
    end else begin : g_none
      assign down[i] = 1'b0;
    end

    fkdeb_lane #(
      .HAS_LONG (i == LONG_KEY_INDEX)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .step (step),
      .down (down[i]),
      .cfg  (cfg),
      .evt  (lane_evt[i])
    );
  end

  // The merge picks the highest-numbered key that fired this tick.
  logic [fkdeb_pkg::CodeWidth-1:0] code;

  fkdeb_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .evt  (lane_evt),
    .code (code)
  );

  // Output register: every accepted scan produces exactly one event item.
  logic [fkdeb_pkg::CodeWidth-1:0] event_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_code <= code;
    end
  end

  assign events.valid      = out_valid;
  assign events.event_code = event_code;

  // An accepted scan always leaves a pending event behind it.
  a_accept_gives_event: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted scan did not produce an event item");

  // The block only holds off scans while an untaken event sits in the output.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !keys.ready |-> (out_valid && !events.ready))
    else $error("scan stalled with the output free");

  // Nothing is pending right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("event pending after reset");

endmodule
